[rtl/hrhp_pkg.sv]
// types and constants shared by the http response header parser
`timescale 1ns / 1ps

package hrhp_pkg;

    // request selectors on the input tuser
    localparam logic [1:0] REQ_DATA           = 2'd0;
    localparam logic [1:0] REQ_RESTART_STATUS = 2'd1;
    localparam logic [1:0] REQ_RESTART_LINE   = 2'd2;

    // result kinds on the output tuser
    localparam logic [2:0] KIND_CODE   = 3'd0;
    localparam logic [2:0] KIND_REASON = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_HEND   = 3'd4;
    localparam logic [2:0] KIND_BEND   = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    // error codes
    localparam logic [3:0] ERR_VERSION_LONG = 4'd0;
    localparam logic [3:0] ERR_NO_VERSION   = 4'd1;
    localparam logic [3:0] ERR_BAD_VERSION  = 4'd2;
    localparam logic [3:0] ERR_CODE_LENGTH  = 4'd3;
    localparam logic [3:0] ERR_CODE_DIGIT   = 4'd4;
    localparam logic [3:0] ERR_REASON_LONG  = 4'd5;
    localparam logic [3:0] ERR_MISSING_LF   = 4'd6;
    localparam logic [3:0] ERR_NAME_LONG    = 4'd7;
    localparam logic [3:0] ERR_NO_NAME      = 4'd8;
    localparam logic [3:0] ERR_HEADER_COUNT = 4'd9;
    localparam logic [3:0] ERR_VALUE_LONG   = 4'd10;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_VERSION = 3'd0;
    localparam logic [2:0] CFG_MAX_REASON  = 3'd1;
    localparam logic [2:0] CFG_MAX_NAME    = 3'd2;
    localparam logic [2:0] CFG_MAX_VALUE   = 3'd3;
    localparam logic [2:0] CFG_MAX_HEADERS = 3'd4;

    // register reset values
    localparam logic [6:0]  RST_MAX_VERSION = 7'd16;
    localparam logic [10:0] RST_MAX_REASON  = 11'd256;
    localparam logic [10:0] RST_MAX_NAME    = 11'd256;
    localparam logic [12:0] RST_MAX_VALUE   = 13'd4096;
    localparam logic [8:0]  RST_MAX_HEADERS = 9'd256;

    localparam int unsigned RUN_W   = 13;
    localparam logic [12:0] VERSION_LEN = 13'd8;
    localparam logic [12:0] CODE_LEN    = 13'd3;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // expected version token, lower case
    localparam logic [7:0] VERSION_TEXT [8] = '{
        8'h68, 8'h74, 8'h74, 8'h70, 8'h2F, 8'h31, 8'h2E, 8'h31
    };

    // parser phases, one-hot
    typedef enum logic [11:0] {
        PH_VERSION    = 12'b0000_0000_0001,
        PH_CODE       = 12'b0000_0000_0010,
        PH_REASON     = 12'b0000_0000_0100,
        PH_REASON_LF  = 12'b0000_0000_1000,
        PH_NAME       = 12'b0000_0001_0000,
        PH_NAME_LF    = 12'b0000_0010_0000,
        PH_VAL_SKIP   = 12'b0000_0100_0000,
        PH_VALUE      = 12'b0000_1000_0000,
        PH_VALUE_LF   = 12'b0001_0000_0000,
        PH_VALUE_PEEK = 12'b0010_0000_0000,
        PH_DONE       = 12'b0100_0000_0000,
        PH_PARKED     = 12'b1000_0000_0000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [9:0] resp_code;
        logic [3:0] error_code;
    } result_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

[rtl/http_response_header_parser_unit.sv]
// http/1.1 response header parser: byte stream in, token stream out
`timescale 1ns / 1ps

//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tdata: data_byte[7:0]; s_tuser: req_type[1:0]
//  m_       out  m_tvalid / m_tready  m_tdata: out_byte[7:0], resp_code[17:8],
//                                     error_code[21:18], zero[23:22];
//                                     m_tuser: kind[2:0]; m_tlast: last_of_run
//  cfg_     in   cfg_we               cfg_index selects register, cfg_data value
//
//  one byte per cycle while m_tready does not stall: a beat is held in the input
//  register, is parsed by one layer of phase logic and lands in the output register
//  after a byte that gives two results (header end plus first byte of next
//  line) the next beat with a result waits in the input register while the
//  second result drains
//  aresetn is synchronous, active low, resets the parser state and returns the limit registers to their reset values
//  a stall on m_tready backs up through the output and input registers to
//  s_tready once a beat with a result is waiting; nothing is dropped

module http_response_header_parser_unit
    import hrhp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [1:0]  s_tuser,   // req_type[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], resp_code[17:8], error_code[21:18]
    output logic [2:0]  m_tuser,   // kind[2:0]
    output logic        m_tlast,   // last_of_run

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    // limit registers
    logic [6:0]  max_version_reg;
    logic [10:0] max_reason_reg;
    logic [10:0] max_name_reg;
    logic [12:0] max_value_reg;
    logic [8:0]  max_headers_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_req_reg;
    logic [7:0]  in_byte_reg;

    // parser state
    phase_t           phase_reg, phase_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             vmatch_reg, vmatch_next;
    logic [9:0]       code_reg, code_next;
    logic [8:0]       hcount_reg, hcount_next;
    logic             named_reg, named_next;

    // results of the byte in the input register
    logic [1:0] n_res;
    result_t    res0, res1;

    // output register plus one pending slot for the second result
    logic    m_valid_reg;
    result_t m_res_reg;
    logic    m_last_reg;
    logic    pend_valid_reg;
    result_t pend_res_reg;

    logic space;
    logic fire;
    logic take;
    logic [7:0] b;

    assign b = in_byte_reg;

    // widened limits for compares against the run length
    logic [RUN_W-1:0] lim_version, lim_reason, lim_name;
    assign lim_version = RUN_W'(max_version_reg);
    assign lim_reason  = RUN_W'(max_reason_reg);
    assign lim_name    = RUN_W'(max_name_reg);

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_version_reg <= RST_MAX_VERSION;
            max_reason_reg  <= RST_MAX_REASON;
            max_name_reg    <= RST_MAX_NAME;
            max_value_reg   <= RST_MAX_VALUE;
            max_headers_reg <= RST_MAX_HEADERS;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_VERSION: max_version_reg <= cfg_data[6:0];
                CFG_MAX_REASON:  max_reason_reg  <= cfg_data[10:0];
                CFG_MAX_NAME:    max_name_reg    <= cfg_data[10:0];
                CFG_MAX_VALUE:   max_value_reg   <= cfg_data;
                CFG_MAX_HEADERS: max_headers_reg <= cfg_data[8:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // parse one byte: next state and up to two results
    // ---------------------------------------------------------------
    always_comb begin
        phase_next  = phase_reg;
        run_next    = run_reg;
        vmatch_next = vmatch_reg;
        code_next   = code_reg;
        hcount_next = hcount_reg;
        named_next  = named_reg;
        n_res       = 2'd0;
        res0        = '0;
        res1        = '0;

        priority if (in_req_reg == REQ_RESTART_STATUS) begin
            phase_next  = PH_VERSION;
            run_next    = '0;
            vmatch_next = 1'b1;
            code_next   = '0;
            hcount_next = '0;
            named_next  = 1'b0;
        end else if (in_req_reg == REQ_RESTART_LINE) begin
            phase_next = PH_NAME;
            run_next   = '0;
            named_next = 1'b0;
        end else if (in_req_reg == REQ_DATA) begin
            unique case (phase_reg)
                PH_VERSION: begin
                    if (b == CH_SPACE) begin
                        if (run_reg == '0) begin
                            n_res = 2'd1; res0.kind = KIND_ERROR;
                            res0.error_code = ERR_NO_VERSION; phase_next = PH_PARKED;
                        end else if (!vmatch_reg || run_reg != VERSION_LEN) begin
                            n_res = 2'd1; res0.kind = KIND_ERROR;
                            res0.error_code = ERR_BAD_VERSION; phase_next = PH_PARKED;
                        end else begin
                            phase_next = PH_CODE;
                            run_next   = '0;
                            code_next  = '0;
                        end
                    end else if (run_reg >= lim_version) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_VERSION_LONG; phase_next = PH_PARKED;
                    end else begin
                        if (run_reg >= VERSION_LEN ||
                            fold_case(b) != VERSION_TEXT[run_reg[2:0]]) begin
                            vmatch_next = 1'b0;
                        end
                        run_next = run_reg + 1'b1;
                    end
                end
                PH_CODE: begin
                    if (b == CH_SPACE) begin
                        if (run_reg != CODE_LEN) begin
                            n_res = 2'd1; res0.kind = KIND_ERROR;
                            res0.error_code = ERR_CODE_LENGTH; phase_next = PH_PARKED;
                        end else begin
                            n_res = 2'd1; res0.kind = KIND_CODE;
                            res0.resp_code = code_reg;
                            phase_next = PH_REASON;
                            run_next   = '0;
                        end
                    end else if (run_reg >= CODE_LEN) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_CODE_LENGTH; phase_next = PH_PARKED;
                    end else if (b < CH_ZERO || b > CH_NINE) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_CODE_DIGIT; phase_next = PH_PARKED;
                    end else begin
                        code_next = 10'(({4'd0, code_reg} * 14'd10) + 14'(b - CH_ZERO));
                        run_next  = run_reg + 1'b1;
                    end
                end
                PH_REASON: begin
                    if (b == CH_CR) begin
                        phase_next = PH_REASON_LF;
                    end else if (run_reg >= lim_reason) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_REASON_LONG; phase_next = PH_PARKED;
                    end else begin
                        run_next = run_reg + 1'b1;
                        n_res = 2'd1; res0.kind = KIND_REASON; res0.out_byte = b;
                    end
                end
                PH_REASON_LF, PH_NAME_LF, PH_VALUE_LF: begin
                    if (b != CH_LF) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_MISSING_LF; phase_next = PH_PARKED;
                    end else if (phase_reg == PH_REASON_LF) begin
                        phase_next = PH_NAME;
                        run_next   = '0;
                        named_next = 1'b0;
                    end else if (phase_reg == PH_VALUE_LF) begin
                        phase_next = PH_VALUE_PEEK;
                    end else if (!named_reg) begin
                        // empty line ends the header block
                        n_res = 2'd1; res0.kind = KIND_BEND; phase_next = PH_DONE;
                    end else if (hcount_reg >= max_headers_reg) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_HEADER_COUNT; phase_next = PH_PARKED;
                    end else begin
                        hcount_next = hcount_reg + 1'b1;
                        n_res = 2'd1; res0.kind = KIND_HEND;
                        phase_next = PH_NAME;
                        run_next   = '0;
                        named_next = 1'b0;
                    end
                end
                PH_NAME: begin
                    if (b == CH_CR) begin
                        phase_next = PH_NAME_LF;
                    end else if (is_blank(b)) begin
                        phase_next = PH_NAME;
                    end else if (b == CH_COLON) begin
                        phase_next = PH_VAL_SKIP;
                        run_next   = '0;
                    end else if (run_reg >= lim_name) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_NAME_LONG; phase_next = PH_PARKED;
                    end else begin
                        run_next   = run_reg + 1'b1;
                        named_next = 1'b1;
                        n_res = 2'd1; res0.kind = KIND_NAME; res0.out_byte = b;
                    end
                end
                PH_VAL_SKIP, PH_VALUE: begin
                    if (phase_reg == PH_VAL_SKIP && is_blank(b)) begin
                        phase_next = PH_VAL_SKIP;
                    end else if (b == CH_CR) begin
                        phase_next = PH_VALUE_LF;
                    end else begin
                        phase_next = PH_VALUE;
                        n_res = 2'd1;
                        if (!named_reg) begin
                            res0.kind = KIND_ERROR;
                            res0.error_code = ERR_NO_NAME; phase_next = PH_PARKED;
                        end else if (run_reg >= max_value_reg) begin
                            res0.kind = KIND_ERROR;
                            res0.error_code = ERR_VALUE_LONG; phase_next = PH_PARKED;
                        end else begin
                            run_next = run_reg + 1'b1;
                            res0.kind = KIND_VALUE; res0.out_byte = b;
                        end
                    end
                end
                PH_VALUE_PEEK: begin
                    if (is_blank(b)) begin
                        // folded line: one space joins the value
                        phase_next = PH_VAL_SKIP;
                        n_res = 2'd1;
                        if (!named_reg) begin
                            res0.kind = KIND_ERROR;
                            res0.error_code = ERR_NO_NAME; phase_next = PH_PARKED;
                        end else if (run_reg >= max_value_reg) begin
                            res0.kind = KIND_ERROR;
                            res0.error_code = ERR_VALUE_LONG; phase_next = PH_PARKED;
                        end else begin
                            run_next = run_reg + 1'b1;
                            res0.kind = KIND_VALUE; res0.out_byte = CH_SPACE;
                        end
                    end else if (!named_reg) begin
                        // nameless line ends the block, byte dropped
                        n_res = 2'd1; res0.kind = KIND_BEND; phase_next = PH_DONE;
                    end else if (hcount_reg >= max_headers_reg) begin
                        n_res = 2'd1; res0.kind = KIND_ERROR;
                        res0.error_code = ERR_HEADER_COUNT; phase_next = PH_PARKED;
                    end else begin
                        // header end, then this byte opens the next line
                        hcount_next = hcount_reg + 1'b1;
                        n_res = 2'd1; res0.kind = KIND_HEND;
                        run_next   = '0;
                        named_next = 1'b0;
                        if (b == CH_CR) begin
                            phase_next = PH_NAME_LF;
                        end else if (b == CH_COLON) begin
                            phase_next = PH_VAL_SKIP;
                        end else if (lim_name == '0) begin
                            n_res = 2'd2; res1.kind = KIND_ERROR;
                            res1.error_code = ERR_NAME_LONG; phase_next = PH_PARKED;
                        end else begin
                            phase_next = PH_NAME;
                            run_next   = RUN_W'(1);
                            named_next = 1'b1;
                            n_res = 2'd2; res1.kind = KIND_NAME; res1.out_byte = b;
                        end
                    end
                end
                PH_DONE, PH_PARKED: ;  // bytes ignored until a restart
                default: ;
            endcase
        end else begin
            // unknown selector: no result, no change
        end
    end

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign take     = m_valid_reg && m_tready;
    assign space    = !pend_valid_reg && (!m_valid_reg || m_tready);
    assign fire     = in_valid_reg && (space || n_res == 2'd0);
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // parser state, advanced once per parsed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_VERSION;
            run_reg    <= '0;
            vmatch_reg <= 1'b1;
            code_reg   <= '0;
            hcount_reg <= '0;
            named_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            run_reg    <= run_next;
            vmatch_reg <= vmatch_next;
            code_reg   <= code_next;
            hcount_reg <= hcount_next;
            named_reg  <= named_next;
        end
    end

    // output register and pending slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (fire && n_res != 2'd0) begin
            m_valid_reg    <= 1'b1;
            pend_valid_reg <= (n_res == 2'd2);
        end else if (take) begin
            m_valid_reg    <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && n_res != 2'd0) begin
            m_res_reg    <= res0;
            m_last_reg   <= (n_res == 2'd1);
            pend_res_reg <= res1;
        end else if (take && pend_valid_reg) begin
            m_res_reg  <= pend_res_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_res_reg.error_code, m_res_reg.resp_code,
                       m_res_reg.out_byte};

endmodule
